FILE: hdl/hac_pkg.sv
`timescale 1ns / 1ps

package hac_pkg;

	localparam logic [1:0] ACT_ACCUM = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0] action;
		logic [9:0] bin_index;
		logic       last;
	} sample_t;

	typedef struct packed {
		logic        is_check;
		logic [9:0]  read_index;
		logic [31:0] bin_value;
		logic [31:0] sample_total;
		logic        check_ok;
	} result_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == TOTAL_MAX) ? v : v + 32'd1;
	endfunction

endpackage

FILE: hdl/hac_bin_ram.sv
`timescale 1ns / 1ps

module hac_bin_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a read and write to one address in a cycle returns old data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

FILE: hdl/hac_clear_sweep.sv
`timescale 1ns / 1ps

module hac_clear_sweep #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic [AW-1:0] addr
);

	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic          busy_q;
	logic [AW-1:0] addr_q;

	// sweep runs out of reset and again on every clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			addr_q <= '0;
		end else if (busy_q) begin
			if (addr_q == LAST_ADDR) begin
				busy_q <= 1'b0;
			end else begin
				addr_q <= addr_q + AW'(1);
			end
		end else if (start) begin
			busy_q <= 1'b1;
			addr_q <= '0;
		end
	end

	assign busy = busy_q;
	assign addr = addr_q;

endmodule

FILE: hdl/histogram_accumulator_core.sv
`timescale 1ns / 1ps
// A result is registered from the stage-1 register into the result register.
// Throughput: one accumulate or read beat per cycle unless a result stall or a
// clear holds the input, using a read-modify-write on the bin RAM with one-entry
// write forwarding. A clear holds the input while a sweep zeroes the RAM.
// Reset (arst_n low) clears the totals and starts the same zeroing sweep.

module histogram_accumulator_core #(
	parameter int HIST_BINS    = 1024,
	parameter int COUNTER_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  hac_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_stall,
	output hac_pkg::result_t result
);

	localparam int AW = $clog2(HIST_BINS);
	localparam logic [COUNTER_BITS-1:0] BIN_MAX = {COUNTER_BITS{1'b1}};

	logic accept;
	logic adv;
	logic in_range;

	// stage 1
	logic                    valid_s1;
	logic [1:0]              action_s1;
	logic [9:0]              index_s1;
	logic                    last_s1;
	logic                    in_range_s1;
	logic [AW-1:0]           addr_s1;

	// last write, forwarded into a read that raced it
	logic                    wr_vld_q;
	logic [AW-1:0]           wr_addr_q;
	logic [COUNTER_BITS-1:0] wr_data_q;

	logic [31:0]             samples_q;
	logic [31:0]             applied_q;

	logic                    result_valid_q;
	hac_pkg::result_t        result_q;

	logic [COUNTER_BITS-1:0] rd_data;
	logic [COUNTER_BITS-1:0] count;
	logic [COUNTER_BITS-1:0] count_inc;
	logic [63:0]             count_wide;
	logic                    apply;
	logic                    is_accum;
	logic                    is_read;
	logic                    is_clear;
	logic [31:0]             samples_nx;
	logic [31:0]             applied_nx;
	logic                    emit;
	hac_pkg::result_t        res_nx;

	logic                    sweep_busy;
	logic [AW-1:0]           sweep_addr;
	logic                    sweep_start;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [COUNTER_BITS-1:0] ram_wdata;

	assign adv          = !result_valid_q || !result_stall;
	assign is_accum     = valid_s1 && (action_s1 == hac_pkg::ACT_ACCUM);
	assign is_read      = valid_s1 && (action_s1 == hac_pkg::ACT_READ);
	assign is_clear     = valid_s1 && (action_s1 == hac_pkg::ACT_CLEAR);
	assign sample_stall = !adv || sweep_busy || is_clear;
	assign accept       = sample_valid && !sample_stall;
	assign in_range     = 32'(sample.bin_index) < 32'(HIST_BINS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1   <= sample.action;
			index_s1    <= sample.bin_index;
			last_s1     <= sample.last;
			in_range_s1 <= in_range;
			addr_s1     <= AW'(sample.bin_index);
		end
	end

	hac_bin_ram #(
		.DEPTH (HIST_BINS),
		.WIDTH (COUNTER_BITS)
	) u_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (AW'(sample.bin_index)),
		.rd_data (rd_data),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata)
	);

	hac_clear_sweep #(
		.DEPTH (HIST_BINS)
	) u_sweep (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sweep_start),
		.busy   (sweep_busy),
		.addr   (sweep_addr)
	);

	assign count      = (wr_vld_q && (wr_addr_q == addr_s1)) ? wr_data_q : rd_data;
	assign count_inc  = count + COUNTER_BITS'(1);
	assign count_wide = 64'(count);
	assign apply      = is_accum && in_range_s1 && (count != BIN_MAX);
	assign samples_nx = hac_pkg::sat_inc(samples_q);
	assign applied_nx = apply ? hac_pkg::sat_inc(applied_q) : applied_q;
	assign sweep_start = is_clear && adv;

	assign ram_we    = sweep_busy || (apply && adv);
	assign ram_waddr = sweep_busy ? sweep_addr : addr_s1;
	assign ram_wdata = sweep_busy ? '0 : count_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else if (sweep_busy) begin
			wr_vld_q <= 1'b0;
		end else if (apply && adv) begin
			wr_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!sweep_busy && apply && adv) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= count_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_q <= '0;
			applied_q <= '0;
		end else if (adv) begin
			if (is_accum) begin
				samples_q <= samples_nx;
				applied_q <= applied_nx;
			end else if (is_clear) begin
				samples_q <= '0;
				applied_q <= '0;
			end
		end
	end

	always_comb begin
		res_nx = '0;
		emit   = 1'b0;
		if (is_accum && last_s1) begin
			emit                = 1'b1;
			res_nx.is_check     = 1'b1;
			res_nx.sample_total = samples_nx;
			res_nx.check_ok     = (applied_nx == samples_nx);
		end else if (is_read) begin
			emit                = 1'b1;
			res_nx.read_index   = index_s1;
			res_nx.sample_total = samples_q;
			if (in_range_s1) begin
				res_nx.bin_value = (count_wide > 64'(hac_pkg::TOTAL_MAX)) ?
					hac_pkg::TOTAL_MAX : count_wide[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			result_q <= res_nx;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: test/hac_checker.sv
`timescale 1ns / 1ps

module hac_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	input  logic             sample_stall,
	input  hac_pkg::sample_t sample,
	input  logic             result_valid,
	input  logic             result_stall,
	input  hac_pkg::result_t result,
	output int               fails,
	output int               pending
);

	localparam int          TABLE_DEPTH = 1024;
	localparam logic [31:0] BIN_TOP     = 32'hFFFF_FFFF;

	logic [31:0]      bin_count [TABLE_DEPTH];
	logic [31:0]      seen_total;
	logic [31:0]      applied_total;
	hac_pkg::result_t owed_results [$];
	hac_pkg::result_t want;

	task automatic report(input string msg);
		$display("[%0t] %s", $time, msg);
		fails++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] exp);
		if (got !== exp)
			report($sformatf("result %s mismatch: got %0h, expected %0h", name, got, exp));
	endtask

	task automatic clear_tables();
		for (int i = 0; i < TABLE_DEPTH; i++)
			bin_count[i] = '0;
		seen_total = '0;
		applied_total = '0;
	endtask

	// Advance the histogram by one accepted beat and queue the result it owes.
	task automatic tally_sample(input hac_pkg::sample_t s);
		hac_pkg::result_t r;
		r = '0;
		case (s.action)
		hac_pkg::ACT_ACCUM: begin
			seen_total = (seen_total == hac_pkg::TOTAL_MAX) ? seen_total : seen_total + 32'd1;
			// a full bin drops the increment but the sample still counts
			if (bin_count[s.bin_index] != BIN_TOP) begin
				bin_count[s.bin_index] = bin_count[s.bin_index] + 32'd1;
				applied_total = (applied_total == hac_pkg::TOTAL_MAX) ?
					applied_total : applied_total + 32'd1;
			end
			if (s.last) begin
				r.is_check = 1'b1;
				r.sample_total = seen_total;
				r.check_ok = (applied_total == seen_total);
				owed_results.push_back(r);
			end
		end
		hac_pkg::ACT_READ: begin
			r.read_index = s.bin_index;
			r.bin_value = bin_count[s.bin_index];
			r.sample_total = seen_total;
			owed_results.push_back(r);
		end
		hac_pkg::ACT_CLEAR: clear_tables();
		default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_tables();
			owed_results.delete();
			pending <= 0;
		end else begin
			// push before pop so a same-edge result still lines up with the oldest
			if (sample_valid && !sample_stall)
				tally_sample(sample);
			if (result_valid && !result_stall) begin
				if (owed_results.size() == 0) begin
					report($sformatf("unexpected result beat %h", result));
				end else begin
					want = owed_results.pop_front();
					check_field("is_check", 32'(result.is_check), 32'(want.is_check));
					check_field("read_index", 32'(result.read_index),
						32'(want.read_index));
					check_field("bin_value", result.bin_value, want.bin_value);
					check_field("sample_total", result.sample_total, want.sample_total);
					check_field("check_ok", 32'(result.check_ok), 32'(want.check_ok));
				end
			end
			pending <= owed_results.size();
		end
	end

endmodule

FILE: test/tb_histogram_accumulator_core.sv
`timescale 1ns / 1ps

module tb_histogram_accumulator_core;

	localparam logic [1:0]  ACT_NOP      = 2'd3;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int          RANDOM_ITEMS = 1250;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             sample_valid = 1'b0;
	logic             sample_stall;
	hac_pkg::sample_t sample       = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	hac_pkg::result_t result;
	logic             calm         = 1'b0;
	int               stall_run    = 0;
	int unsigned      cycle_n      = 0;
	int               fails;
	int               pending;

	always #5 clk = ~clk;

	histogram_accumulator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	hac_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.fails        (fails),
		.pending      (pending)
	);

	// mostly short, now and then long
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// hot bins give back-to-back hits on the same counter
	function automatic logic [9:0] pick_bin(input logic [9:0] hot);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 10'd0;
		if (r == 1)
			return 10'd1023;
		if (r < 6)
			return hot + 10'($urandom_range(0, 3));
		return 10'($urandom_range(0, 1023));
	endfunction

	always @(posedge clk) begin
		if (stall_run != 0) begin
			result_stall <= 1'b1;
			stall_run <= stall_run - 1;
		end else if (!calm && $urandom_range(0, 99) < 20) begin
			result_stall <= 1'b1;
			stall_run <= pick_len() - 1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_n <= cycle_n + 1;
		if (cycle_n == CYCLE_LIMIT) begin
			$display("histogram_accumulator_core regression: fail");
			$finish;
		end
	end

	task automatic push_beat(input logic [1:0] act, input logic [9:0] idx, input logic lst);
		sample <= hac_pkg::sample_t'{act, idx, lst};
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		if (!calm && $urandom_range(0, 99) < 35) begin
			sample_valid <= 1'b0;
			repeat (pick_len())
				@(posedge clk);
		end
	endtask

	initial begin
		int         sent;
		int         set_len;
		int         r;
		logic [1:0] act;
		logic [9:0] hot;

		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;

		// fresh table, both ends of the index range
		push_beat(hac_pkg::ACT_READ, 10'd0, 1'b0);
		push_beat(hac_pkg::ACT_READ, 10'd1023, 1'b0);
		push_beat(hac_pkg::ACT_ACCUM, 10'd0, 1'b0);
		push_beat(hac_pkg::ACT_ACCUM, 10'd1023, 1'b0);
		push_beat(hac_pkg::ACT_ACCUM, 10'd1023, 1'b1);
		// same bin back to back, then read right behind the write
		push_beat(hac_pkg::ACT_ACCUM, 10'd5, 1'b0);
		push_beat(hac_pkg::ACT_ACCUM, 10'd5, 1'b0);
		push_beat(hac_pkg::ACT_ACCUM, 10'd5, 1'b0);
		push_beat(hac_pkg::ACT_READ, 10'd5, 1'b0);
		push_beat(hac_pkg::ACT_ACCUM, 10'd5, 1'b1);
		push_beat(hac_pkg::ACT_READ, 10'd5, 1'b1);
		push_beat(hac_pkg::ACT_ACCUM, 10'h2AA, 1'b0);
		push_beat(hac_pkg::ACT_ACCUM, 10'h155, 1'b1);
		push_beat(hac_pkg::ACT_READ, 10'h2AA, 1'b0);
		push_beat(hac_pkg::ACT_READ, 10'd1023, 1'b0);
		// unknown action must leave everything alone
		push_beat(ACT_NOP, 10'd1023, 1'b1);
		push_beat(ACT_NOP, 10'd0, 1'b0);
		push_beat(hac_pkg::ACT_READ, 10'd0, 1'b0);
		// clear with last set gives no result
		push_beat(hac_pkg::ACT_CLEAR, 10'h3FF, 1'b1);
		push_beat(hac_pkg::ACT_READ, 10'd1023, 1'b0);
		push_beat(hac_pkg::ACT_READ, 10'd5, 1'b0);
		push_beat(hac_pkg::ACT_ACCUM, 10'h155, 1'b1);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			calm <= ($urandom_range(0, 99) < 15);
			r = $urandom_range(0, 99);
			if (r < 2) begin
				push_beat(hac_pkg::ACT_CLEAR, 10'($urandom_range(0, 1023)),
					1'($urandom_range(0, 1)));
				sent++;
			end else if (r < 8) begin
				// stray beats: any action, any flag
				repeat ($urandom_range(1, 4)) begin
					act = 2'($urandom_range(0, 3));
					push_beat(act, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
					if (act != ACT_NOP)
						sent++;
				end
			end else begin
				hot = 10'($urandom_range(0, 1023));
				set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) :
					$urandom_range(1, 16);
				for (int k = 0; k < set_len; k++) begin
					if ($urandom_range(0, 3) == 0) begin
						push_beat(hac_pkg::ACT_READ, pick_bin(hot), 1'b0);
						sent++;
					end
					push_beat(hac_pkg::ACT_ACCUM, pick_bin(hot), k == set_len - 1);
					sent++;
				end
			end
		end

		sample_valid <= 1'b0;
		calm <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
		if (fails == 0)
			$display("histogram_accumulator_core regression: pass");
		else
			$display("histogram_accumulator_core regression: fail");
		$finish;
	end

endmodule

FILE: histogram_accumulator_core.f
hdl/hac_pkg.sv
hdl/hac_bin_ram.sv
hdl/hac_clear_sweep.sv
hdl/histogram_accumulator_core.sv
test/hac_checker.sv
test/tb_histogram_accumulator_core.sv
